// ===== hdl/locc_pkg.sv =====
// Package with shared types and constants of the lock-order cycle checker.
package locc_pkg;
    localparam int MAX_LOCKS   = 32;
    localparam int STACK_DEPTH = 16;
    localparam int THREADS     = 4;
    localparam int LOCK_W      = 5;
    localparam int THR_W       = 2;
    localparam int LVL_W       = 5;
    localparam int RANK_W      = 6;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_OUT_ORDER = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_TOP, S_CHK, S_RD_EDGE, S_CHK_EDGE, S_CLR, S_OUT
    } t_state;

    // Phases of the depth-first search.
    typedef enum logic [1:0] {
        P_IDLE, P_ROOT, P_READ, P_SCAN
    } t_phase;

    typedef struct packed {
        logic             deadlock;
        logic [LOCK_W-1:0] cfrom;
        logic [LOCK_W-1:0] cto;
        logic [1:0]       status;
    } t_result;
endpackage

// ===== hdl/locc_search.sv =====
// Depth-first search over the edge matrix kept in a synchronous memory.
module locc_search import locc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_wr,
    input  logic [LOCK_W-1:0] i_wr_row,
    input  logic [LOCK_W-1:0] i_wr_col,
    input  logic [LOCK_W-1:0] i_rd_row,
    output logic [MAX_LOCKS-1:0] o_rd_data,
    output logic              o_done,
    output logic              o_found,
    output logic [LOCK_W-1:0] o_from,
    output logic [LOCK_W-1:0] o_to
);
    // Edge matrix: one row per lock, cleared after reset by a sweep.
    logic [MAX_LOCKS-1:0] mem [MAX_LOCKS];
    logic [MAX_LOCKS-1:0] r_row;
    logic [RANK_W-1:0] rank [MAX_LOCKS];
    logic [MAX_LOCKS-1:0] r_vis, r_fin;
    logic [LOCK_W-1:0] wnode [MAX_LOCKS];
    logic [RANK_W-1:0] wnext [MAX_LOCKS];
    logic [RANK_W-1:0] r_sp, r_rank;
    logic [RANK_W-1:0] r_root;
    t_phase r_ph, n_ph;
    logic [LOCK_W-1:0] r_here;
    logic [RANK_W-1:0] r_nx;
    logic [LOCK_W:0] r_clr;
    logic [LOCK_W-1:0] there;
    logic back_edge;

    assign o_rd_data = r_row;
    assign there = r_nx[LOCK_W-1:0];
    assign back_edge = (rank[r_here] >= rank[there]) && !r_fin[there];

    // Memory port: clear sweep, edge insertion from the registered row, and the row read.
    // The row register holds still while a row is being scanned.
    always_ff @(posedge i_clk) begin
        if (!r_clr[LOCK_W]) begin
            mem[r_clr[LOCK_W-1:0]] <= '0;
        end else if (i_wr) begin
            mem[i_wr_row] <= r_row | (MAX_LOCKS'(1) << i_wr_col);
        end
        if (r_ph == P_READ) begin
            r_row <= mem[r_here];
        end else if (r_ph == P_IDLE) begin
            r_row <= mem[i_rd_row];
        end
    end

    // Next search phase.
    always_comb begin
        n_ph = r_ph;
        case (r_ph)
            P_IDLE: if (i_start) n_ph = P_ROOT;
            P_ROOT: begin
                if (r_root == RANK_W'(MAX_LOCKS)) n_ph = P_IDLE;
                else if (!r_vis[r_root[LOCK_W-1:0]]) n_ph = P_READ;
            end
            P_READ: n_ph = P_SCAN;
            P_SCAN: begin
                if (r_nx == RANK_W'(MAX_LOCKS)) begin
                    n_ph = (r_sp == RANK_W'(1)) ? P_ROOT : P_READ;
                end else if (r_row[there]) begin
                    if (!r_vis[there]) begin
                        if (r_sp < RANK_W'(MAX_LOCKS)) n_ph = P_READ;
                    end else if (back_edge) begin
                        n_ph = P_IDLE;
                    end
                end
            end
            default: n_ph = P_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_ph <= P_IDLE;
            o_done <= 1'b0;
        end else begin
            if (!r_clr[LOCK_W]) r_clr <= r_clr + 1'b1;
            r_ph <= n_ph;
            o_done <= 1'b0;
            case (r_ph)
                P_IDLE: if (i_start) begin
                    r_vis <= '0; r_fin <= '0; r_rank <= '0; r_root <= '0;
                    o_found <= 1'b0; o_from <= '0; o_to <= '0;
                end
                P_ROOT: begin
                    // Next root, or end of search.
                    if (r_root == RANK_W'(MAX_LOCKS)) begin
                        o_done <= 1'b1;
                    end else if (r_vis[r_root[LOCK_W-1:0]]) begin
                        r_root <= r_root + 1'b1;
                    end else begin
                        r_vis[r_root[LOCK_W-1:0]] <= 1'b1;
                        rank[r_root[LOCK_W-1:0]] <= r_rank;
                        r_rank <= r_rank + 1'b1;
                        wnode[0] <= r_root[LOCK_W-1:0];
                        r_here <= r_root[LOCK_W-1:0];
                        r_nx <= '0;
                        r_sp <= RANK_W'(1);
                        r_root <= r_root + 1'b1;
                    end
                end
                P_SCAN: begin
                    // Scan one neighbour of the top node per cycle; a move to another node first rereads its row.
                    if (r_nx == RANK_W'(MAX_LOCKS)) begin
                        r_fin[r_here] <= 1'b1;
                        if (r_sp != RANK_W'(1)) begin
                            r_here <= wnode[r_sp[LOCK_W-1:0] - 2'd2];
                            r_nx <= wnext[r_sp[LOCK_W-1:0] - 2'd2];
                            r_sp <= r_sp - 1'b1;
                        end
                    end else if (!r_row[there]) begin
                        r_nx <= r_nx + 1'b1;
                    end else if (!r_vis[there]) begin
                        r_vis[there] <= 1'b1;
                        rank[there] <= r_rank;
                        r_rank <= r_rank + 1'b1;
                        if (r_sp < RANK_W'(MAX_LOCKS)) begin
                            wnext[r_sp[LOCK_W-1:0] - 1'b1] <= r_nx + 1'b1;
                            wnode[r_sp[LOCK_W-1:0]] <= there;
                            r_sp <= r_sp + 1'b1;
                            r_here <= there;
                            r_nx <= '0;
                        end else begin
                            r_nx <= r_nx + 1'b1;
                        end
                    end else if (back_edge) begin
                        o_found <= 1'b1; o_from <= r_here; o_to <= there;
                        o_done <= 1'b1;
                    end else begin
                        r_nx <= r_nx + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end
endmodule

// ===== hdl/lock_order_cycle_checker.sv =====
// Top level of the lock-order cycle checker: held-lock stacks and control.
//  channel   dir  handshake             payload
//  s_axis    in   i_s_axis_tvalid/ready  action, thread, lock_num
//  m_axis    out  o_m_axis_tvalid/ready  deadlock, cycle_from, cycle_to, status
// One item at a time. An acquire that adds an edge runs a search that scans
// one neighbour a cycle, pausing for a row read whenever it moves to another node.
// After reset a sweep clears the edge memory before items are taken.
// The result waits in an output register until the master side takes it.
module lock_order_cycle_checker import locc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,  // action, thread[1:0], lock_num[4:0]
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata  // deadlock, cycle_from, cycle_to, status, pad
);
    t_state r_state, n_state;
    logic [LOCK_W-1:0] hstack [THREADS*STACK_DEPTH];
    logic [LVL_W-1:0] r_lvl [THREADS];
    logic [LOCK_W-1:0] r_top;
    logic r_act;
    logic [THR_W-1:0] r_thr;
    logic [LOCK_W-1:0] r_lock;
    logic [LVL_W-1:0] lvl;
    logic [LOCK_W:0] r_wait;
    t_result r_res;
    logic start, wr, done, found;
    logic [LOCK_W-1:0] from, to;
    logic [MAX_LOCKS-1:0] row;

    assign lvl = r_lvl[r_thr];
    assign o_s_axis_tready = (r_state == S_IDLE) && r_wait[LOCK_W];
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tdata = {3'b0, r_res.status, r_res.cto, r_res.cfrom, r_res.deadlock};

    locc_search u_search (
        .i_clk, .i_rst_n, .i_start(start), .i_wr(wr), .i_wr_row(r_top),
        .i_wr_col(r_lock), .i_rd_row(r_top), .o_rd_data(row), .o_done(done),
        .o_found(found), .o_from(from), .o_to(to)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        start = 1'b0;
        wr = 1'b0;
        case (r_state)
            S_IDLE:     if (o_s_axis_tready && i_s_axis_tvalid) n_state = S_RD_TOP;
            S_RD_TOP:   n_state = S_CHK;
            S_CHK: begin
                if (r_act || lvl >= LVL_W'(STACK_DEPTH) || lvl == '0 || r_top == r_lock)
                    n_state = S_OUT;
                else n_state = S_RD_EDGE;
            end
            S_RD_EDGE:  n_state = S_CHK_EDGE;
            S_CHK_EDGE: begin
                if (row[r_lock]) n_state = S_OUT;
                else begin
                    wr = 1'b1; start = 1'b1; n_state = S_CLR;
                end
            end
            S_CLR:      if (done) n_state = S_OUT;
            S_OUT:      if (i_m_axis_tready) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait <= '0;
            for (int t = 0; t < THREADS; t++) r_lvl[t] <= '0;
        end else begin
            r_state <= n_state;
            if (!r_wait[LOCK_W]) r_wait <= r_wait + 1'b1;
            if (r_state == S_IDLE && n_state == S_RD_TOP) begin
                r_act <= i_s_axis_tdata[0];
                r_thr <= i_s_axis_tdata[2:1];
                r_lock <= i_s_axis_tdata[7:3];
                r_res <= '0;
            end
            // Stack top read, registered.
            if (r_state == S_RD_TOP)
                r_top <= hstack[{r_thr, 4'(lvl - 1'b1)}];
            if (r_state == S_CHK) begin
                if (r_act) begin
                    if (lvl == '0) r_res.status <= ST_EMPTY;
                    else begin
                        if (r_top != r_lock) r_res.status <= ST_OUT_ORDER;
                        r_lvl[r_thr] <= lvl - 1'b1;
                    end
                end else if (lvl >= LVL_W'(STACK_DEPTH)) begin
                    r_res.status <= ST_FULL;
                end else begin
                    hstack[{r_thr, lvl[3:0]}] <= r_lock;
                    r_lvl[r_thr] <= lvl + 1'b1;
                end
            end
            if (r_state == S_CLR && done) begin
                r_res.deadlock <= found;
                r_res.cfrom <= from;
                r_res.cto <= to;
            end
        end
    end

    // A result is offered only once its item has been taken.
    a_out_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_m_axis_tvalid) else $error("stray result");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid) else $error("result lost");
    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_s_axis_tready) else $error("ready while busy");
endmodule
